/* rtl/core/bgpio_pkg.sv */
// Shared constants and types for the banked GPIO register block.
// Holds the register map, bank geometry and access-kind codes.
// No dependencies.
`timescale 1ns / 1ps

package bgpio_pkg;

    // Bank geometry
    localparam int NUM_BANKS  = 5;
    localparam int BANK_WIDTH = 32;
    localparam int BANK_IDX_W = 3;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 10;

    // Pin-count configuration registers
    localparam int NUM_CFG   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int PINS_W    = 6;

    localparam logic [PINS_W-1:0] PINS_RESET [NUM_CFG] = '{
        6'd26, 6'd26, 6'd0, 6'd32, 6'd32
    };

    // Register map (byte offsets)
    localparam int OFS_DATA_LOW  = 'h000;
    localparam int OFS_DATA_HIGH = 'h004;
    localparam int STEP_DATA     = 'h08;
    localparam int OFS_DATA_RO   = 'h060;
    localparam int STEP_RO       = 'h04;
    localparam int OFS_DIR       = 'h204;
    localparam int OFS_OE        = 'h208;
    localparam int STEP_CTRL     = 'h40;

    // Mask-data word layout: mask in the upper half, data in the lower half
    localparam logic [DATA_W-1:0] MASK_HALF = 32'hFFFF_0000;
    localparam int                HALF_PINS = 16;

    // All pins of a full bank present
    localparam logic [DATA_W-1:0] FULL_MASK = DATA_W'((64'd1 << BANK_WIDTH) - 64'd1);

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_DLOW,
        KIND_DHIGH,
        KIND_RO,
        KIND_DIR,
        KIND_OE
    } kind_t;

endpackage

/* rtl/core/banked_gpio_register_block_top.sv */
// Banked GPIO register block: mask-data, direction and output-enable registers.
// Depends on bgpio_pkg for the register map, bank geometry and access kinds.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-----------------------------------------
//  access in | in        | in_valid / in_ready   | func, reg_address, write_data, pad_levels
//  result    | out       | out_valid / out_ready | read_data, access_error, drive_bank,
//            |           |                       | drive_levels, drive_enables
//  config    | in        | cfg_write (no wait)   | cfg_index, cfg_data
//
// One access per cycle is sustained while results are taken. An accepted beat sits
// in the input register, where decode and the masked update run, and moves on to
// the result register when that register is free, which makes the result valid.
// Bank state is written at the same edge, so the following beat sees it.
// Reset clears all bank registers and loads the default pin counts.
// A stalled result holds the input register; in_ready drops only then.
`timescale 1ns / 1ps

module banked_gpio_register_block_top (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic [bgpio_pkg::ADDR_W-1:0]         reg_address,
    input  logic [bgpio_pkg::DATA_W-1:0]         write_data,
    input  logic [bgpio_pkg::DATA_W-1:0]         pad_levels,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bgpio_pkg::DATA_W-1:0]         read_data,
    output logic                                 access_error,
    output logic [bgpio_pkg::BANK_IDX_W-1:0]     drive_bank,
    output logic [bgpio_pkg::DATA_W-1:0]         drive_levels,
    output logic [bgpio_pkg::DATA_W-1:0]         drive_enables,

    input  logic                                 cfg_write,
    input  logic [bgpio_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bgpio_pkg::PINS_W-1:0]         cfg_data
);

    // Input register
    logic                              in_valid_reg;
    logic                              in_func_reg;
    logic [bgpio_pkg::ADDR_W-1:0]      in_addr_reg;
    logic [bgpio_pkg::DATA_W-1:0]      in_wdata_reg;
    logic [bgpio_pkg::DATA_W-1:0]      in_pads_reg;

    // Result register
    logic                              out_valid_reg;
    logic [bgpio_pkg::DATA_W-1:0]      read_data_reg;
    logic                              access_error_reg;
    logic [bgpio_pkg::BANK_IDX_W-1:0]  drive_bank_reg;
    logic [bgpio_pkg::DATA_W-1:0]      drive_levels_reg;
    logic [bgpio_pkg::DATA_W-1:0]      drive_enables_reg;

    // Bank state and pin counts
    logic [bgpio_pkg::DATA_W-1:0]      out_data_reg  [bgpio_pkg::NUM_BANKS];
    logic [bgpio_pkg::DATA_W-1:0]      dir_reg       [bgpio_pkg::NUM_BANKS];
    logic [bgpio_pkg::DATA_W-1:0]      oe_reg        [bgpio_pkg::NUM_BANKS];
    logic [bgpio_pkg::PINS_W-1:0]      pins_reg      [bgpio_pkg::NUM_CFG];

    // Computed values for the beat in the input register
    bgpio_pkg::kind_t                  kind;
    logic [bgpio_pkg::BANK_IDX_W-1:0]  bank;
    logic [bgpio_pkg::PINS_W-1:0]      pin_count;
    logic [bgpio_pkg::DATA_W-1:0]      present;
    logic [bgpio_pkg::DATA_W-1:0]      data_next;
    logic [bgpio_pkg::DATA_W-1:0]      dir_next;
    logic [bgpio_pkg::DATA_W-1:0]      oe_next;
    logic [bgpio_pkg::DATA_W-1:0]      read_data_next;
    logic                              access_error_next;
    logic [bgpio_pkg::BANK_IDX_W-1:0]  drive_bank_next;
    logic [bgpio_pkg::DATA_W-1:0]      drive_levels_next;
    logic [bgpio_pkg::DATA_W-1:0]      drive_enables_next;

    logic                              out_free;
    logic                              advance;

    // Flow control: the result register frees when empty or taken
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // Decode the address into access kind and bank
    always_comb
    begin
        kind = bgpio_pkg::KIND_NONE;
        bank = '0;
        for (int b = 0; b < bgpio_pkg::NUM_BANKS; b++)
        begin
            if (in_addr_reg == bgpio_pkg::ADDR_W'(bgpio_pkg::OFS_DATA_LOW
                                                  + bgpio_pkg::STEP_DATA * b))
            begin
                kind = bgpio_pkg::KIND_DLOW;
                bank = bgpio_pkg::BANK_IDX_W'(b);
            end
            if (in_addr_reg == bgpio_pkg::ADDR_W'(bgpio_pkg::OFS_DATA_HIGH
                                                  + bgpio_pkg::STEP_DATA * b))
            begin
                kind = bgpio_pkg::KIND_DHIGH;
                bank = bgpio_pkg::BANK_IDX_W'(b);
            end
            if (in_addr_reg == bgpio_pkg::ADDR_W'(bgpio_pkg::OFS_DATA_RO
                                                  + bgpio_pkg::STEP_RO * b))
            begin
                kind = bgpio_pkg::KIND_RO;
                bank = bgpio_pkg::BANK_IDX_W'(b);
            end
            if (in_addr_reg == bgpio_pkg::ADDR_W'(bgpio_pkg::OFS_DIR
                                                  + bgpio_pkg::STEP_CTRL * b))
            begin
                kind = bgpio_pkg::KIND_DIR;
                bank = bgpio_pkg::BANK_IDX_W'(b);
            end
            if (in_addr_reg == bgpio_pkg::ADDR_W'(bgpio_pkg::OFS_OE
                                                  + bgpio_pkg::STEP_CTRL * b))
            begin
                kind = bgpio_pkg::KIND_OE;
                bank = bgpio_pkg::BANK_IDX_W'(b);
            end
        end
    end

    // Mask of present pins; banks without a count register are absent
    always_comb
    begin
        pin_count = '0;
        for (int b = 0; b < bgpio_pkg::NUM_CFG; b++)
        begin
            if (bank == bgpio_pkg::BANK_IDX_W'(b))
            begin
                pin_count = pins_reg[b];
            end
        end
        if (pin_count >= bgpio_pkg::PINS_W'(bgpio_pkg::BANK_WIDTH))
        begin
            present = bgpio_pkg::FULL_MASK;
        end
        else
        begin
            present = (bgpio_pkg::DATA_W'(1) << pin_count) - bgpio_pkg::DATA_W'(1);
        end
    end

    // Apply the access to the addressed bank and form the result
    always_comb
    begin
        logic [bgpio_pkg::DATA_W-1:0] sel;
        logic [bgpio_pkg::DATA_W-1:0] bits;
        logic [bgpio_pkg::DATA_W-1:0] upd;
        logic [bgpio_pkg::DATA_W-1:0] rd;
        logic                         err;

        sel       = (~in_wdata_reg & bgpio_pkg::MASK_HALF) >> bgpio_pkg::HALF_PINS;
        bits      = in_wdata_reg & ~bgpio_pkg::MASK_HALF;
        if (kind == bgpio_pkg::KIND_DHIGH)
        begin
            sel  = sel << bgpio_pkg::HALF_PINS;
            bits = bits << bgpio_pkg::HALF_PINS;
        end
        upd       = sel & present;
        rd        = '0;
        err       = 1'b0;
        data_next = out_data_reg[bank];
        dir_next  = dir_reg[bank];
        oe_next   = oe_reg[bank];

        if (kind == bgpio_pkg::KIND_NONE || present == '0)
        begin
            err = 1'b1;
        end
        else
        begin
            unique case (kind) inside
                bgpio_pkg::KIND_DLOW, bgpio_pkg::KIND_DHIGH:
                begin
                    if (in_func_reg)
                    begin
                        err       = |(sel & ~present);
                        data_next = (out_data_reg[bank] & ~upd) | (bits & upd);
                    end
                end
                bgpio_pkg::KIND_RO:
                begin
                    if (in_func_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        rd = in_pads_reg & present;
                    end
                end
                bgpio_pkg::KIND_DIR:
                begin
                    if (in_func_reg)
                    begin
                        err      = |(in_wdata_reg & ~present);
                        dir_next = in_wdata_reg & present;
                    end
                    else
                    begin
                        rd = dir_reg[bank];
                    end
                end
                bgpio_pkg::KIND_OE:
                begin
                    if (in_func_reg)
                    begin
                        err     = |(in_wdata_reg & ~present);
                        oe_next = in_wdata_reg & present;
                    end
                    else
                    begin
                        rd = oe_reg[bank];
                    end
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        read_data_next    = (in_func_reg || err) ? '0 : rd;
        access_error_next = err;
        if (kind == bgpio_pkg::KIND_NONE)
        begin
            drive_bank_next    = '0;
            drive_levels_next  = '0;
            drive_enables_next = '0;
        end
        else
        begin
            drive_bank_next    = bank;
            drive_levels_next  = data_next;
            drive_enables_next = dir_next & oe_next;
        end
    end

    // Hold control state, bank registers and pin counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < bgpio_pkg::NUM_BANKS; b++)
            begin
                out_data_reg[b] <= '0;
                dir_reg[b]      <= '0;
                oe_reg[b]       <= '0;
            end
            for (int c = 0; c < bgpio_pkg::NUM_CFG; c++)
            begin
                pins_reg[c] <= bgpio_pkg::PINS_RESET[c];
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                out_data_reg[bank] <= data_next;
                dir_reg[bank]      <= dir_next;
                oe_reg[bank]       <= oe_next;
            end
            if (cfg_write && cfg_index < bgpio_pkg::CFG_IDX_W'(bgpio_pkg::NUM_CFG))
            begin
                pins_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Capture the incoming beat and the finished result
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_func_reg  <= func;
            in_addr_reg  <= reg_address;
            in_wdata_reg <= write_data;
            in_pads_reg  <= pad_levels;
        end
        if (advance)
        begin
            read_data_reg     <= read_data_next;
            access_error_reg  <= access_error_next;
            drive_bank_reg    <= drive_bank_next;
            drive_levels_reg  <= drive_levels_next;
            drive_enables_reg <= drive_enables_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign access_error  = access_error_reg;
    assign drive_bank    = drive_bank_reg;
    assign drive_levels  = drive_levels_reg;
    assign drive_enables = drive_enables_reg;

    // An error result never carries read data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && access_error |-> read_data == '0)
        else $error("error result with nonzero read data");

    // Reported bank always exists
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_bank < bgpio_pkg::BANK_IDX_W'(bgpio_pkg::NUM_BANKS))
        else $error("drive bank out of range");

    // Input stalls only behind a result that waits to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // A beat held in the input register reaches the output once it frees
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready ##1 out_ready |=> out_valid)
        else $error("held beat lost");

endmodule

/* dv/banked_gpio_register_block_top_tb.sv */
// Self-checking testbench for the banked GPIO register block.
// Uses bgpio_pkg for geometry, register map and access kinds; drives the top level
// through its access, result and pin-count configuration ports.
`timescale 1ns / 1ps

module banked_gpio_register_block_top_tb;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_SLACK     = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int HOLD_OFF_PHASE  = 0;
    localparam int PAUSE_PHASE     = 3;

    typedef struct packed {
        logic                         func;
        logic [bgpio_pkg::ADDR_W-1:0] addr;
        logic [bgpio_pkg::DATA_W-1:0] wdata;
        logic [bgpio_pkg::DATA_W-1:0] pads;
    } access_t;

    typedef struct packed {
        logic [bgpio_pkg::DATA_W-1:0]     read_data;
        logic                             access_error;
        logic [bgpio_pkg::BANK_IDX_W-1:0] drive_bank;
        logic [bgpio_pkg::DATA_W-1:0]     drive_levels;
        logic [bgpio_pkg::DATA_W-1:0]     drive_enables;
    } result_t;

    // Shadow of the bank registers; predicts each access and checks results in order
    class gpio_bank_shadow;
        logic [bgpio_pkg::PINS_W-1:0] pins [bgpio_pkg::NUM_CFG];
        logic [bgpio_pkg::DATA_W-1:0] data_q [bgpio_pkg::NUM_BANKS];
        logic [bgpio_pkg::DATA_W-1:0] dir_q [bgpio_pkg::NUM_BANKS];
        logic [bgpio_pkg::DATA_W-1:0] oe_q [bgpio_pkg::NUM_BANKS];
        result_t                      expected_results [$];
        int unsigned                  mismatches;

        function new();
            foreach (pins[i]) pins[i] = bgpio_pkg::PINS_RESET[i];
            foreach (data_q[i])
            begin
                data_q[i] = '0;
                dir_q[i]  = '0;
                oe_q[i]   = '0;
            end
            mismatches = 0;
        endfunction

        function int reg_offset(bgpio_pkg::kind_t k, int b);
            case (k)
                bgpio_pkg::KIND_DLOW:
                    return bgpio_pkg::OFS_DATA_LOW + bgpio_pkg::STEP_DATA * b;
                bgpio_pkg::KIND_DHIGH:
                    return bgpio_pkg::OFS_DATA_HIGH + bgpio_pkg::STEP_DATA * b;
                bgpio_pkg::KIND_RO:
                    return bgpio_pkg::OFS_DATA_RO + bgpio_pkg::STEP_RO * b;
                bgpio_pkg::KIND_DIR:
                    return bgpio_pkg::OFS_DIR + bgpio_pkg::STEP_CTRL * b;
                default:
                    return bgpio_pkg::OFS_OE + bgpio_pkg::STEP_CTRL * b;
            endcase
        endfunction

        function void set_pins(int idx, logic [bgpio_pkg::PINS_W-1:0] val);
            if (idx < bgpio_pkg::NUM_CFG) pins[idx] = val;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function result_t predict(access_t a);
            bgpio_pkg::kind_t             kind;
            int                           bank;
            int                           n;
            int                           shift;
            logic [bgpio_pkg::DATA_W-1:0] present;
            logic [bgpio_pkg::DATA_W-1:0] sel;
            logic [bgpio_pkg::DATA_W-1:0] bits;
            logic [bgpio_pkg::DATA_W-1:0] upd;
            logic [bgpio_pkg::DATA_W-1:0] rd;
            logic                         err;
            logic                         wr;
            result_t                      r;
            kind = bgpio_pkg::KIND_NONE;
            bank = 0;
            rd   = '0;
            err  = 1'b0;
            wr   = (a.func == FUNC_WRITE);
            r    = '0;

            // Decode the byte offset into a register kind and bank
            for (int b = 0; b < bgpio_pkg::NUM_BANKS; b++)
            begin
                if (kind == bgpio_pkg::KIND_NONE)
                begin
                    if (int'(a.addr) == reg_offset(bgpio_pkg::KIND_DLOW, b))
                        kind = bgpio_pkg::KIND_DLOW;
                    else if (int'(a.addr) == reg_offset(bgpio_pkg::KIND_DHIGH, b))
                        kind = bgpio_pkg::KIND_DHIGH;
                    else if (int'(a.addr) == reg_offset(bgpio_pkg::KIND_RO, b))
                        kind = bgpio_pkg::KIND_RO;
                    else if (int'(a.addr) == reg_offset(bgpio_pkg::KIND_DIR, b))
                        kind = bgpio_pkg::KIND_DIR;
                    else if (int'(a.addr) == reg_offset(bgpio_pkg::KIND_OE, b))
                        kind = bgpio_pkg::KIND_OE;
                    if (kind != bgpio_pkg::KIND_NONE) bank = b;
                end
            end

            // Unmapped: error with all other fields zero
            if (kind == bgpio_pkg::KIND_NONE)
            begin
                r.access_error = 1'b1;
                return r;
            end

            // Saturate the pin count at the bank width
            n = (bank < bgpio_pkg::NUM_CFG) ? int'(pins[bank]) : 0;
            if (n > bgpio_pkg::BANK_WIDTH) n = bgpio_pkg::BANK_WIDTH;
            present = bgpio_pkg::DATA_W'((64'd1 << n) - 64'd1);

            if (present == '0)
                err = 1'b1;
            else
            begin
                case (kind) inside
                    bgpio_pkg::KIND_DLOW, bgpio_pkg::KIND_DHIGH:
                    begin
                        if (wr)
                        begin
                            shift = (kind == bgpio_pkg::KIND_DHIGH) ? bgpio_pkg::HALF_PINS : 0;
                            sel   = ((~a.wdata & bgpio_pkg::MASK_HALF)
                                     >> bgpio_pkg::HALF_PINS) << shift;
                            bits  = (a.wdata & ~bgpio_pkg::MASK_HALF) << shift;
                            upd   = sel & present;
                            if ((sel & ~present) != '0) err = 1'b1;
                            data_q[bank] = (data_q[bank] & ~upd) | (bits & upd);
                        end
                    end
                    bgpio_pkg::KIND_RO:
                    begin
                        if (wr) err = 1'b1;
                        else rd = a.pads & present;
                    end
                    default:
                    begin
                        if (wr)
                        begin
                            if ((a.wdata & ~present) != '0) err = 1'b1;
                            if (kind == bgpio_pkg::KIND_DIR) dir_q[bank] = a.wdata & present;
                            else oe_q[bank] = a.wdata & present;
                        end
                        else
                            rd = (kind == bgpio_pkg::KIND_DIR) ? dir_q[bank] : oe_q[bank];
                    end
                endcase
            end

            r.read_data     = (wr || err) ? '0 : rd;
            r.access_error  = err;
            r.drive_bank    = bgpio_pkg::BANK_IDX_W'(bank);
            r.drive_levels  = data_q[bank];
            r.drive_enables = dir_q[bank] & oe_q[bank];
            return r;
        endfunction

        function void note_access(access_t a);
            expected_results.push_back(predict(a));
        endfunction

        function void compare_field(string field, logic [bgpio_pkg::DATA_W-1:0] want,
                                    logic [bgpio_pkg::DATA_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, expected none actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("access_error", bgpio_pkg::DATA_W'(want.access_error),
                          bgpio_pkg::DATA_W'(got.access_error));
            compare_field("drive_bank", bgpio_pkg::DATA_W'(want.drive_bank),
                          bgpio_pkg::DATA_W'(got.drive_bank));
            compare_field("drive_levels", want.drive_levels, got.drive_levels);
            compare_field("drive_enables", want.drive_enables, got.drive_enables);
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic                             func;
    logic [bgpio_pkg::ADDR_W-1:0]     reg_address;
    logic [bgpio_pkg::DATA_W-1:0]     write_data;
    logic [bgpio_pkg::DATA_W-1:0]     pad_levels;
    logic                             out_valid;
    logic                             out_ready;
    logic [bgpio_pkg::DATA_W-1:0]     read_data;
    logic                             access_error;
    logic [bgpio_pkg::BANK_IDX_W-1:0] drive_bank;
    logic [bgpio_pkg::DATA_W-1:0]     drive_levels;
    logic [bgpio_pkg::DATA_W-1:0]     drive_enables;
    logic                             cfg_write;
    logic [bgpio_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bgpio_pkg::PINS_W-1:0]     cfg_data;

    gpio_bank_shadow shadow;
    int unsigned     burst_left;
    int unsigned     idle_cycles;
    bit              hold_off_req;

    banked_gpio_register_block_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .reg_address   (reg_address),
        .write_data    (write_data),
        .pad_levels    (pad_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .access_error  (access_error),
        .drive_bank    (drive_bank),
        .drive_levels  (drive_levels),
        .drive_enables (drive_enables),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one beat and hold it until accepted; record it at the accepting edge
    task automatic drive_item(access_t a);
        in_valid    <= 1'b1;
        func        <= a.func;
        reg_address <= a.addr;
        write_data  <= a.wdata;
        pad_levels  <= a.pads;
        do @(posedge clk); while (!in_ready);
        shadow.note_access(a);
    endtask

    // Send a beat inside a burst; open a new burst after a random gap
    task automatic send_beat(access_t a);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        drive_item(a);
    endtask

    task automatic send_at(logic f, int addr, logic [bgpio_pkg::DATA_W-1:0] wd,
                           logic [bgpio_pkg::DATA_W-1:0] pads);
        send_beat('{func: f, addr: bgpio_pkg::ADDR_W'(addr), wdata: wd, pads: pads});
    endtask

    // Drop valid and wait until every expected result is back, then let the pipe settle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Write all pin counts back to back, then one unused index that must be ignored
    task automatic program_pins(logic [bgpio_pkg::PINS_W-1:0] vals [bgpio_pkg::NUM_CFG]);
        for (int i = 0; i < bgpio_pkg::NUM_CFG; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= bgpio_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            shadow.set_pins(i, vals[i]);
        end
        cfg_index <= bgpio_pkg::CFG_IDX_W'(bgpio_pkg::NUM_CFG
                     + $urandom_range(0, (1 << bgpio_pkg::CFG_IDX_W) - 1 - bgpio_pkg::NUM_CFG));
        cfg_data  <= bgpio_pkg::PINS_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [bgpio_pkg::PINS_W-1:0] random_pins();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return bgpio_pkg::PINS_W'(bgpio_pkg::BANK_WIDTH);
            2: return bgpio_pkg::PINS_W'($urandom_range(bgpio_pkg::BANK_WIDTH + 1,
                                                        (1 << bgpio_pkg::PINS_W) - 1));
            default: return bgpio_pkg::PINS_W'($urandom_range(1, bgpio_pkg::BANK_WIDTH - 1));
        endcase
    endfunction

    function automatic logic [bgpio_pkg::PINS_W-1:0] pins_for_phase(int phase, int idx);
        logic [bgpio_pkg::PINS_W-1:0] edge_set [bgpio_pkg::NUM_CFG];
        logic [bgpio_pkg::PINS_W-1:0] over_set [bgpio_pkg::NUM_CFG];
        edge_set = '{6'd1, 6'd16, 6'd17, 6'd31, 6'd63};
        over_set = '{6'd33, 6'd0, 6'd32, 6'd15, 6'd40};
        case (phase)
            0: return bgpio_pkg::PINS_W'(bgpio_pkg::BANK_WIDTH);
            1: return '0;
            2: return edge_set[idx];
            3: return over_set[idx];
            default: return random_pins();
        endcase
    endfunction

    // Mostly mapped registers with random content, some raw addresses as noise
    function automatic access_t random_access();
        access_t          a;
        bgpio_pkg::kind_t k;
        int               b;
        a.func = ($urandom_range(0, 99) < 60) ? FUNC_WRITE : FUNC_READ;
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 4))
                0: k = bgpio_pkg::KIND_DLOW;
                1: k = bgpio_pkg::KIND_DHIGH;
                2: k = bgpio_pkg::KIND_RO;
                3: k = bgpio_pkg::KIND_DIR;
                default: k = bgpio_pkg::KIND_OE;
            endcase
            b = $urandom_range(0, bgpio_pkg::NUM_BANKS - 1);
            a.addr = bgpio_pkg::ADDR_W'(shadow.reg_offset(k, b));
        end
        else
            a.addr = bgpio_pkg::ADDR_W'($urandom_range(0, (1 << bgpio_pkg::ADDR_W) - 1));
        case ($urandom_range(0, 4))
            0: a.wdata = $urandom;
            1: a.wdata = $urandom >> $urandom_range(1, bgpio_pkg::DATA_W - 1);
            2: a.wdata = $urandom & ~bgpio_pkg::MASK_HALF;
            3: a.wdata = (bgpio_pkg::MASK_HALF
                          & ~(32'h1 << $urandom_range(bgpio_pkg::HALF_PINS,
                                                      bgpio_pkg::DATA_W - 1)))
                         | ($urandom & ~bgpio_pkg::MASK_HALF);
            default: a.wdata = ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
        a.pads = $urandom;
        return a;
    endfunction

    // Directed accesses under the reset pin counts (26, 26, absent, 32, 32)
    task automatic run_directed();
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_DLOW, 0), '1, '1);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DLOW, 0), 32'h0000_FFFF, '0);
        // unmasked high data beyond the pin count
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DHIGH, 0), 32'h0000_FFFF, '0);
        // fully masked write leaves data alone
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DHIGH, 0), '1, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DLOW, 0), 32'hFFFE_0000, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DIR, 0), '1, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_OE, 0), 32'h03FF_FFFF, '0);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_DIR, 0), '0, '0);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_OE, 0), '0, '0);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_RO, 0), '0, '1);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_RO, 1), '1, '1);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_RO, 3), '0, 32'hA5A5_5A5A);
        // absent bank
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DLOW, 2), 32'h0000_FFFF, '0);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_DIR, 2), '0, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DIR, 3), '1, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_OE, 3), '0, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_OE, 4), '1, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DIR, 4), 32'h8000_0001, '0);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_DHIGH, 4), 32'h0000_8001, '0);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_DHIGH, 4), '0, '1);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_OE, 4), '0, '0);
        // unmapped offsets, including just past the last registers
        send_at(FUNC_READ,  (1 << bgpio_pkg::ADDR_W) - 1, '0, '1);
        send_at(FUNC_WRITE, 'h002, '1, '0);
        send_at(FUNC_READ,  shadow.reg_offset(bgpio_pkg::KIND_RO, bgpio_pkg::NUM_BANKS),
                '0, '1);
        send_at(FUNC_WRITE, shadow.reg_offset(bgpio_pkg::KIND_OE, bgpio_pkg::NUM_BANKS),
                '1, '0);
    endtask

    // Receiver: random ready pattern in runs, with an occasional long hold-off
    initial
    begin : receiver
        int hold_left;
        int run_left;
        int ready_pct;
        hold_left = 0;
        run_left  = 0;
        ready_pct = 100;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready    <= 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (hold_left > 0)
                hold_left--;
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(4, 80);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                run_left--;
                out_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin : result_monitor
        result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {read_data, access_error, drive_bank, drive_levels, drive_enables};
            shadow.check_result(seen);
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [bgpio_pkg::PINS_W-1:0] cfg_vals [bgpio_pkg::NUM_CFG];
        shadow       = new();
        burst_left   = 0;
        hold_off_req = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_READ;
        reg_address <= '0;
        write_data  <= '0;
        pad_levels  <= '0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        run_directed();
        wait_for_results();

        // Random phases, each under its own pin-count setting
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            for (int i = 0; i < bgpio_pkg::NUM_CFG; i++) cfg_vals[i] = pins_for_phase(phase, i);
            program_pins(cfg_vals);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // stall the result side while input keeps coming
                if (phase == HOLD_OFF_PHASE && n == ITEMS_PER_PHASE / 2)
                begin
                    hold_off_req = 1'b1;
                    burst_left   = 24;
                end
                // pause the input until the block has drained
                if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                send_beat(random_access());
            end
            wait_for_results();
        end

        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
